// File: rtl/qau_pkg.sv
package qau_pkg;

  // default fixed-point format, Q16.16
  localparam int FRAC_BITS_DEF = 16;

  // opcodes
  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SCL  = 3'd2;
  localparam logic [2:0] OP_CONJ = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // Hamilton product: term t of row r is a[t]*b[r^t]; a set bit subtracts that term
  localparam logic [3:0] HSUB [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_w;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_w;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_w;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic [1:0]         status;
  } out_t;

  // request state carried down the long pipe; index 0 is w
  typedef struct packed {
    logic [2:0]       op;
    logic [3:0][31:0] res;
    logic [1:0]       status;
    logic [3:0][31:0] mag;
    logic [3:0]       neg;
  } mid_t;

endpackage

// File: rtl/qau_front.sv
module qau_front #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         v_i,
  input  qau_pkg::in_t d_i,
  output logic         v_o,
  output qau_pkg::mid_t m_o,
  output logic [64:0]  rad_o
);
  import qau_pkg::*;

  localparam logic signed [66:0] RND  = 67'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [66:0] QMAX = 67'sd2147483647;
  localparam logic signed [66:0] QMIN = -67'sd2147483648;

  logic signed [31:0] qa [4];
  logic signed [31:0] qb [4];

  assign qa[0] = d_i.a_w;
  assign qa[1] = d_i.a_x;
  assign qa[2] = d_i.a_y;
  assign qa[3] = d_i.a_z;
  assign qb[0] = d_i.b_w;
  assign qb[1] = d_i.b_x;
  assign qb[2] = d_i.b_y;
  assign qb[3] = d_i.b_z;

  // stage 1: sixteen products, plus add / conjugate results
  logic               v1_r;
  logic [2:0]         op1_r;
  logic signed [63:0] p1_r [4][4];
  logic signed [63:0] p1_nxt [4][4];
  logic [3:0][31:0]   ar1_r, ar1_nxt;
  logic               sat1_r, sat1_nxt;
  logic [3:0][31:0]   mag1_r, mag1_nxt;
  logic [3:0]         neg1_r, neg1_nxt;

  always_comb begin
    logic signed [31:0] opa;
    logic signed [31:0] opb;
    for (int r = 0; r < 4; r++) begin
      for (int t = 0; t < 4; t++) begin
        opa = qa[t];
        opb = qb[2'(r ^ t)];
        case (d_i.opcode)
          OP_MUL: ;
          OP_SCL: begin
            opa = qa[r];
            opb = (t == 0) ? d_i.scale : 32'sd0;
          end
          OP_NORM: opb = (r == 0) ? qa[t] : 32'sd0;
          default: opb = 32'sd0;
        endcase
        p1_nxt[r][t] = opa * opb;
      end
    end
  end

  always_comb begin
    logic [32:0] e;
    sat1_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      mag1_nxt[i] = qa[i][31] ? (~qa[i] + 32'd1) : qa[i];
      neg1_nxt[i] = qa[i][31];
      case (d_i.opcode)
        OP_ADD:  e = {qa[i][31], qa[i]} + {qb[i][31], qb[i]};
        OP_CONJ: e = (i == 0) ? {qa[i][31], qa[i]} : (33'd0 - {qa[i][31], qa[i]});
        default: e = '0;
      endcase
      if (e[32] != e[31]) begin
        ar1_nxt[i] = e[32] ? Q_MIN : Q_MAX;
        sat1_nxt   = 1'b1;
      end else begin
        ar1_nxt[i] = e[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= d_i.opcode;
      p1_r   <= p1_nxt;
      ar1_r  <= ar1_nxt;
      sat1_r <= sat1_nxt;
      mag1_r <= mag1_nxt;
      neg1_r <= neg1_nxt;
    end
  end

  // stage 2: signed row sums, exact
  logic               v2_r;
  logic [2:0]         op2_r;
  logic signed [65:0] s2_r [4];
  logic signed [65:0] s2_nxt [4];
  logic [3:0][31:0]   ar2_r;
  logic               sat2_r;
  logic [3:0][31:0]   mag2_r;
  logic [3:0]         neg2_r;

  always_comb begin
    logic signed [65:0] acc;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int t = 0; t < 4; t++) begin
        if ((op1_r == OP_MUL) && HSUB[r][t]) begin
          acc = acc - 66'(p1_r[r][t]);
        end else begin
          acc = acc + 66'(p1_r[r][t]);
        end
      end
      s2_nxt[r] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      s2_r   <= s2_nxt;
      ar2_r  <= ar1_r;
      sat2_r <= sat1_r;
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
    end
  end

  // stage 3: round half up, saturate, select per opcode
  logic          v3_r;
  mid_t          m3_r, m3_nxt;
  logic [64:0]   rad3_r;

  always_comb begin
    logic signed [66:0] t;
    logic signed [66:0] q;
    logic [3:0][31:0]   rr;
    logic               rs;
    rs = 1'b0;
    for (int r = 0; r < 4; r++) begin
      t = 67'(s2_r[r]) + RND;
      q = t >>> FRAC_BITS;
      if (q > QMAX) begin
        rr[r] = Q_MAX;
        rs    = 1'b1;
      end else if (q < QMIN) begin
        rr[r] = Q_MIN;
        rs    = 1'b1;
      end else begin
        rr[r] = q[31:0];
      end
    end
    m3_nxt.op  = op2_r;
    m3_nxt.mag = mag2_r;
    m3_nxt.neg = neg2_r;
    case (op2_r)
      OP_MUL, OP_SCL: begin
        m3_nxt.res    = rr;
        m3_nxt.status = rs ? ST_SAT : ST_OK;
      end
      OP_ADD, OP_CONJ: begin
        m3_nxt.res    = ar2_r;
        m3_nxt.status = sat2_r ? ST_SAT : ST_OK;
      end
      default: begin
        m3_nxt.res    = '0;
        m3_nxt.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r   <= m3_nxt;
      rad3_r <= s2_r[0][64:0];
    end
  end

  assign v_o   = v3_r;
  assign m_o   = m3_r;
  assign rad_o = rad3_r;

endmodule

// File: rtl/qau_sqrt.sv
module qau_sqrt (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  qau_pkg::mid_t m_i,
  input  logic [64:0]   rad_i,
  output logic          v_o,
  output qau_pkg::mid_t m_o,
  output logic [32:0]   root_o
);
  import qau_pkg::*;

  // one root bit per stage, restoring digit-by-digit square root
  localparam int SQ_N = 33;

  logic        v_r   [SQ_N];
  mid_t        m_r   [SQ_N];
  logic [66:0] rem_r [SQ_N];
  logic [66:0] res_r [SQ_N];

  for (genvar j = 0; j < SQ_N; j++) begin : g_st
    localparam logic [66:0] BITV = 67'd1 << (64 - 2 * j);

    logic        v_in;
    mid_t        m_in;
    logic [66:0] rem_in, res_in, rem_nxt, res_nxt, trial;

    if (j == 0) begin : g_first
      assign v_in   = v_i;
      assign m_in   = m_i;
      assign rem_in = 67'(rad_i);
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = v_r[j-1];
      assign m_in   = m_r[j-1];
      assign rem_in = rem_r[j-1];
      assign res_in = res_r[j-1];
    end

    always_comb begin
      trial = res_in + BITV;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BITV;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j]   <= m_in;
        rem_r[j] <= rem_nxt;
        res_r[j] <= res_nxt;
      end
    end
  end

  assign v_o    = v_r[SQ_N-1];
  assign m_o    = m_r[SQ_N-1];
  assign root_o = res_r[SQ_N-1][32:0];

endmodule

// File: rtl/qau_div.sv
module qau_div #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_i,
  input  qau_pkg::mid_t m_i,
  input  logic [32:0]   root_i,
  output logic          v_o,
  output qau_pkg::out_t d_o
);
  import qau_pkg::*;

  localparam int DN = FRAC_BITS + 1;   // quotient bits, one per stage
  localparam int NW = FRAC_BITS + 34;  // dividend / remainder width

  // entry: dividend = |c| * 2^F + norm/2, for round half away from zero
  logic          ve_r;
  mid_t          me_r;
  logic [32:0]   roote_r;
  logic [NW-1:0] nume_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      me_r    <= m_i;
      roote_r <= root_i;
      for (int l = 0; l < 4; l++) begin
        nume_r[l] <= (NW'(m_i.mag[l]) << FRAC_BITS) + NW'(root_i >> 1);
      end
    end
  end

  // restoring divider, four lanes, stage j settles quotient bit F-j
  logic          v_r    [DN];
  mid_t          m_r    [DN];
  logic [32:0]   root_r [DN];
  logic [NW-1:0] rem_r  [DN][4];
  logic [DN-1:0] q_r    [DN][4];

  for (genvar j = 0; j < DN; j++) begin : g_st
    localparam int K = FRAC_BITS - j;

    logic          v_in;
    mid_t          m_in;
    logic [32:0]   root_in;
    logic [NW-1:0] rem_in  [4];
    logic [DN-1:0] q_in    [4];
    logic [NW-1:0] rem_nxt [4];
    logic [DN-1:0] q_nxt   [4];
    logic [NW-1:0] dv;

    if (j == 0) begin : g_first
      assign v_in    = ve_r;
      assign m_in    = me_r;
      assign root_in = roote_r;
      assign rem_in  = nume_r;
      assign q_in    = '{default: '0};
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign m_in    = m_r[j-1];
      assign root_in = root_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign q_in    = q_r[j-1];
    end

    always_comb begin
      dv = NW'(root_in) << K;
      for (int l = 0; l < 4; l++) begin
        if (rem_in[l] >= dv) begin
          rem_nxt[l] = rem_in[l] - dv;
          q_nxt[l]   = q_in[l] | (DN'(1) << K);
        end else begin
          rem_nxt[l] = rem_in[l];
          q_nxt[l]   = q_in[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j]    <= m_in;
        root_r[j] <= root_in;
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
      end
    end
  end

  // final select: normalize result or the value carried from the front end
  always_comb begin
    logic [3:0][31:0] rr;
    logic [1:0]       st;
    logic [31:0]      qq;
    rr = m_r[DN-1].res;
    st = m_r[DN-1].status;
    qq = '0;
    if (m_r[DN-1].op == OP_NORM) begin
      if (root_r[DN-1] == 33'd0) begin
        rr = '0;
        st = ST_ZERO;
      end else begin
        st = ST_OK;
        for (int l = 0; l < 4; l++) begin
          qq    = 32'(q_r[DN-1][l]);
          rr[l] = m_r[DN-1].neg[l] ? (32'd0 - qq) : qq;
        end
      end
    end
    d_o.res_w  = rr[0];
    d_o.res_x  = rr[1];
    d_o.res_y  = rr[2];
    d_o.res_z  = rr[3];
    d_o.status = st;
  end

  assign v_o = v_r[DN-1];

endmodule

// File: rtl/quaternion_arithmetic_unit.sv
// Quaternion ALU, signed fixed point with FRAC_BITS fraction bits (Q16.16 default).
// Input channel: in_valid / in_stall / in_data carries opcode, quaternions a, b
// and a scalar. Result channel: out_valid / out_stall / out_data carries the
// quaternion result and a status (ok, saturated, normalize of zero).
// A request moves when valid is high and stall is low on that channel.
// Every opcode runs down the same pipeline, so results leave in request order.
// Path from accept to out_valid: input register, three front stages (products,
// sums, rounding), a 33-stage square root, a divider entry stage, FRAC_BITS + 1
// divider stages (one quotient bit each, Q16.16 by default) and the output
// register. Throughput is one request per clock while in_stall is low.
// When the receiver stalls, the result waits in the output register and one
// more result drops into a skid register; only when that skid register is
// full does in_stall rise and the whole pipe hold, so nothing is lost.
// Synchronous active-low reset empties the pipe and both output registers.
module quaternion_arithmetic_unit #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qau_pkg::out_t out_data
);
  import qau_pkg::*;

  logic  pipe_en;
  logic  ov_r, sv_r;
  out_t  od_r, sd_r;

  assign pipe_en  = !sv_r;
  assign in_stall = sv_r;

  // input register
  logic v0_r;
  in_t  d0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (pipe_en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      d0_r <= in_data;
    end
  end

  logic        f_v;
  mid_t        f_m;
  logic [64:0] f_rad;
  logic        q_v;
  mid_t        q_m;
  logic [32:0] q_root;
  logic        p_v;
  out_t        p_d;

  qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .v_i   (v0_r),
    .d_i   (d0_r),
    .v_o   (f_v),
    .m_o   (f_m),
    .rad_o (f_rad)
  );

  qau_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .v_i    (f_v),
    .m_i    (f_m),
    .rad_i  (f_rad),
    .v_o    (q_v),
    .m_o    (q_m),
    .root_o (q_root)
  );

  qau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .v_i    (q_v),
    .m_i    (q_m),
    .root_i (q_root),
    .v_o    (p_v),
    .d_o    (p_d)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (!ov_r || !out_stall) begin
      if (sv_r) begin
        ov_r <= 1'b1;
        sv_r <= 1'b0;
      end else begin
        ov_r <= p_v;
      end
    end else if (!sv_r && p_v) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov_r || !out_stall) begin
      od_r <= sv_r ? sd_r : p_d;
    end else if (!sv_r) begin
      sd_r <= p_d;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r)
    else $error("skid entry held while output register empty");

  a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ZERO) |->
      (out_data.res_w == 32'sd0 && out_data.res_x == 32'sd0 &&
       out_data.res_y == 32'sd0 && out_data.res_z == 32'sd0))
    else $error("zero-norm status with nonzero components");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_SAT ||
                   out_data.status == ST_ZERO))
    else $error("undefined status code");

endmodule
